>>> hw/rtl/sfdm_pkg.sv
package sfdm_pkg;

  // Image geometry and sampling grid
  localparam int unsigned IMAGE_WIDTH  = 160;
  localparam int unsigned IMAGE_HEIGHT = 120;
  localparam int unsigned SAMPLE_STEP  = 4;

  localparam int unsigned GRID_COLS = (IMAGE_WIDTH + SAMPLE_STEP - 1) / SAMPLE_STEP;
  localparam int unsigned GRID_ROWS = (IMAGE_HEIGHT + SAMPLE_STEP - 1) / SAMPLE_STEP;
  localparam int unsigned GRID_SIZE = GRID_COLS * GRID_ROWS;

  // Field widths
  localparam int unsigned PIX_W = 8;
  localparam int unsigned COL_W = 8;
  localparam int unsigned ROW_W = 7;
  localparam int unsigned CNT_W = 11;
  localparam int unsigned THR_W = 8;

  localparam int unsigned PH_W   = (SAMPLE_STEP > 1) ? $clog2(SAMPLE_STEP) : 1;
  localparam int unsigned GCOL_W = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int unsigned IDX_W  = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD,
    CFG_ROI_START,
    CFG_ROI_END,
    CFG_REPORT_LIMIT
  } cfg_idx_e;

  localparam logic [THR_W-1:0] THRESHOLD_RST    = THR_W'(30);
  localparam logic [ROW_W-1:0] ROI_START_RST    = ROW_W'(0);
  localparam logic [ROW_W-1:0] ROI_END_RST      = ROW_W'(120);
  localparam logic [CNT_W-1:0] REPORT_LIMIT_RST = CNT_W'(1200);

  // Result kinds
  localparam logic KIND_COORD   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [THR_W-1:0] threshold;
    logic [ROW_W-1:0] roi_start;
    logic [ROW_W-1:0] roi_end;
    logic [CNT_W-1:0] report_limit;
  } cfg_t;

  // One pixel request on its way to evaluation
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_last;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             on_grid;
    logic [IDX_W-1:0] idx;
  } item_t;

  typedef struct packed {
    logic             kind;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [CNT_W-1:0] changed_count;
    logic             motion;
    logic             run_last;
  } res_t;

endpackage

>>> hw/rtl/sfdm_if.sv
interface sfdm_pix_if;
  logic                      valid;
  logic                      ready;
  logic [sfdm_pkg::PIX_W-1:0] pixel;
  logic                      frame_last;

  modport source (output valid, output pixel, output frame_last, input ready);
  modport sink   (input valid, input pixel, input frame_last, output ready);
endinterface

interface sfdm_res_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [sfdm_pkg::COL_W-1:0] col;
  logic [sfdm_pkg::ROW_W-1:0] row;
  logic [sfdm_pkg::CNT_W-1:0] changed_count;
  logic                      motion;
  logic                      run_last;

  modport source (output valid, output kind, output col, output row,
                  output changed_count, output motion, output run_last, input ready);
  modport sink   (input valid, input kind, input col, input row,
                  input changed_count, input motion, input run_last, output ready);
endinterface

>>> hw/rtl/sfdm_scan.sv
module sfdm_scan (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  sfdm_pix_if.sink                     pix_i,
  input  logic                         adv_i,
  output logic                         s1_valid_o,
  output sfdm_pkg::item_t              s1_item_o,
  output logic                         rd_en_o,
  output logic [sfdm_pkg::IDX_W-1:0]   rd_idx_o
);

  logic [sfdm_pkg::COL_W-1:0]  col_q, col_d;
  logic [sfdm_pkg::ROW_W-1:0]  row_q, row_d;
  logic [sfdm_pkg::PH_W-1:0]   cph_q, cph_d;
  logic [sfdm_pkg::PH_W-1:0]   rph_q, rph_d;
  logic [sfdm_pkg::GCOL_W-1:0] gcol_q, gcol_d;
  logic [sfdm_pkg::IDX_W-1:0]  rbase_q, rbase_d;
  logic                        s1_valid_q, s1_valid_d;
  sfdm_pkg::item_t             s1_q, item;
  logic                        accept;

  // Take a new request whenever the evaluation slot is free or drains now
  assign pix_i.ready = !s1_valid_q || adv_i;
  assign accept      = pix_i.valid && pix_i.ready;

  // Describe the current raster position
  always_comb begin
    item.pixel      = pix_i.pixel;
    item.frame_last = pix_i.frame_last;
    item.col        = col_q;
    item.row        = row_q;
    item.on_grid    = (cph_q == '0) && (rph_q == '0);
    item.idx        = sfdm_pkg::IDX_W'(rbase_q + sfdm_pkg::IDX_W'(gcol_q));
  end

  assign rd_en_o  = accept;
  assign rd_idx_o = item.idx;

  // Advance the raster and grid counters
  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    cph_d   = cph_q;
    rph_d   = rph_q;
    gcol_d  = gcol_q;
    rbase_d = rbase_q;
    if (accept) begin
      if (pix_i.frame_last) begin
        col_d   = '0;
        row_d   = '0;
        cph_d   = '0;
        rph_d   = '0;
        gcol_d  = '0;
        rbase_d = '0;
      end else if (col_q == sfdm_pkg::COL_W'(sfdm_pkg::IMAGE_WIDTH - 1)) begin
        col_d  = '0;
        cph_d  = '0;
        gcol_d = '0;
        if (row_q == sfdm_pkg::ROW_W'(sfdm_pkg::IMAGE_HEIGHT - 1)) begin
          row_d   = '0;
          rph_d   = '0;
          rbase_d = '0;
        end else begin
          row_d = row_q + 1'b1;
          if (rph_q == sfdm_pkg::PH_W'(sfdm_pkg::SAMPLE_STEP - 1)) begin
            rph_d   = '0;
            rbase_d = rbase_q + sfdm_pkg::IDX_W'(sfdm_pkg::GRID_COLS);
          end else begin
            rph_d = rph_q + 1'b1;
          end
        end
      end else begin
        col_d = col_q + 1'b1;
        if (cph_q == sfdm_pkg::PH_W'(sfdm_pkg::SAMPLE_STEP - 1)) begin
          cph_d  = '0;
          gcol_d = gcol_q + 1'b1;
        end else begin
          cph_d = cph_q + 1'b1;
        end
      end
    end
  end

  // Hold the request until evaluation takes it
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (adv_i) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      cph_q      <= '0;
      rph_q      <= '0;
      gcol_q     <= '0;
      rbase_q    <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      cph_q      <= cph_d;
      rph_q      <= rph_d;
      gcol_q     <= gcol_d;
      rbase_q    <= rbase_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= item;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_item_o  = s1_q;

endmodule

>>> hw/rtl/sfdm_ref_mem.sv
module sfdm_ref_mem (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_en_i,
  input  logic [sfdm_pkg::IDX_W-1:0]  rd_idx_i,
  input  logic                        wr_en_i,
  input  logic [sfdm_pkg::IDX_W-1:0]  wr_idx_i,
  input  logic [sfdm_pkg::PIX_W-1:0]  wr_data_i,
  output logic [sfdm_pkg::PIX_W-1:0]  rd_data_o
);

  logic [sfdm_pkg::PIX_W-1:0] mem_q [sfdm_pkg::GRID_SIZE];
  logic [sfdm_pkg::PIX_W-1:0] rd_raw_q;
  logic [sfdm_pkg::PIX_W-1:0] byp_data_q;
  logic                       byp_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_data_i;
    end
  end

  // Read port, held between reads
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_raw_q   <= mem_q[rd_idx_i];
      byp_data_q <= wr_data_i;
    end
  end

  // Forward a write to the entry being read in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (rd_en_i) begin
      byp_q <= wr_en_i && (wr_idx_i == rd_idx_i);
    end
  end

  assign rd_data_o = byp_q ? byp_data_q : rd_raw_q;

endmodule

>>> hw/rtl/sfdm_eval.sv
module sfdm_eval (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sfdm_pkg::cfg_t              cfg_i,
  input  logic                        s1_valid_i,
  input  sfdm_pkg::item_t             s1_item_i,
  input  logic [sfdm_pkg::PIX_W-1:0]  ref_i,
  output logic                        adv_o,
  output logic                        wr_en_o,
  output logic [sfdm_pkg::IDX_W-1:0]  wr_idx_o,
  output logic [sfdm_pkg::PIX_W-1:0]  wr_data_o,
  sfdm_res_if.source                  res_o
);

  logic                       first_q, first_d;
  logic [sfdm_pkg::CNT_W-1:0] cnt_q, cnt_d, cnt_next;
  sfdm_pkg::res_t             out_q, out_d, pend_q, pend_d;
  logic                       out_valid_q, out_valid_d;
  logic                       pend_valid_q, pend_valid_d;
  sfdm_pkg::res_t             coord, summary;
  logic [sfdm_pkg::PIX_W-1:0] diff;
  logic                       in_roi, hit, emit_sum, space, taken;

  // Evaluate only when both results of this request have room
  assign taken = out_valid_q && res_o.ready;
  assign space = !pend_valid_q && (!out_valid_q || res_o.ready);
  assign adv_o = s1_valid_i && space;

  // Compare against the stored reference
  always_comb begin
    diff     = (s1_item_i.pixel > ref_i) ? s1_item_i.pixel - ref_i
                                         : ref_i - s1_item_i.pixel;
    in_roi   = (s1_item_i.row >= cfg_i.roi_start) && (s1_item_i.row < cfg_i.roi_end);
    hit      = s1_item_i.on_grid && !first_q && in_roi && (diff > cfg_i.threshold) &&
               (cnt_q < cfg_i.report_limit);
    cnt_next = cnt_q + sfdm_pkg::CNT_W'(hit);
    emit_sum = s1_item_i.frame_last && !first_q;
  end

  // Build both result forms
  always_comb begin
    coord.kind          = sfdm_pkg::KIND_COORD;
    coord.col           = s1_item_i.col;
    coord.row           = s1_item_i.row;
    coord.changed_count = '0;
    coord.motion        = 1'b0;
    coord.run_last      = !s1_item_i.frame_last;

    summary.kind          = sfdm_pkg::KIND_SUMMARY;
    summary.col           = '0;
    summary.row           = '0;
    summary.changed_count = cnt_next;
    summary.motion        = (cnt_next != '0);
    summary.run_last      = 1'b1;
  end

  // Refresh the reference of every grid pixel
  assign wr_en_o   = adv_o && s1_item_i.on_grid;
  assign wr_idx_o  = s1_item_i.idx;
  assign wr_data_o = s1_item_i.pixel;

  // Fill the output register and the pending slot
  always_comb begin
    out_d        = out_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q && !res_o.ready;
    pend_valid_d = pend_valid_q;
    if (adv_o) begin
      if (hit) begin
        out_d        = coord;
        out_valid_d  = 1'b1;
        pend_d       = summary;
        pend_valid_d = emit_sum;
      end else if (emit_sum) begin
        out_d       = summary;
        out_valid_d = 1'b1;
      end
    end else if (taken && pend_valid_q) begin
      out_d        = pend_q;
      out_valid_d  = 1'b1;
      pend_valid_d = 1'b0;
    end
  end

  // Track frame state
  always_comb begin
    first_d = first_q;
    cnt_d   = cnt_q;
    if (adv_o) begin
      if (s1_item_i.frame_last) begin
        first_d = 1'b0;
        cnt_d   = '0;
      end else begin
        cnt_d = cnt_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q      <= 1'b1;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      first_q      <= first_d;
      cnt_q        <= cnt_d;
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pend_q <= pend_d;
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.kind          = out_q.kind;
  assign res_o.col           = out_q.col;
  assign res_o.row           = out_q.row;
  assign res_o.changed_count = out_q.changed_count;
  assign res_o.motion        = out_q.motion;
  assign res_o.run_last      = out_q.run_last;

  // A pending summary always sits behind a coordinate in the output register
  a_pend_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> out_valid_q)
    else $error("pending result without an output result");

  a_pend_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> (out_q.kind == sfdm_pkg::KIND_COORD) && !out_q.run_last &&
                     (pend_q.kind == sfdm_pkg::KIND_SUMMARY))
    else $error("pending slot holds results out of order");

  // The first frame only fills the references
  a_first_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    first_q |-> !out_valid_q)
    else $error("result produced during the first frame");

endmodule

>>> hw/rtl/sparse_frame_difference_motion.sv
// Motion detector for a raster greyscale stream. Each accepted pixel is placed
// on the image by internal column and row counters; pixels whose column and row
// are both multiples of the sampling step are compared with their stored
// reference (one byte per grid point, one read and one write port, read data
// registered) and then replace it. One pixel is accepted every cycle while the
// output drains and nothing is pending. A frame's last pixel that reports a
// changed coordinate yields two results and holds the input until the second
// leaves the pending slot. The first frame after reset only fills the
// references and yields nothing. The reference store is not cleared at reset.
// Configuration must be written only while no pixel is in flight; unenforced.
module sparse_frame_difference_motion (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  sfdm_pix_if.sink                        pix_i,
  sfdm_res_if.source                      res_o,
  input  logic                            cfg_we_i,
  input  logic [sfdm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sfdm_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  sfdm_pkg::cfg_t             cfg_q, cfg_d;
  sfdm_pkg::item_t            s1_item;
  logic                       s1_valid, adv;
  logic                       rd_en, wr_en;
  logic [sfdm_pkg::IDX_W-1:0] rd_idx, wr_idx;
  logic [sfdm_pkg::PIX_W-1:0] wr_data, rd_data;

  // Apply configuration writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (sfdm_pkg::cfg_idx_e'(cfg_idx_i))
        sfdm_pkg::CFG_THRESHOLD:    cfg_d.threshold    = cfg_data_i[sfdm_pkg::THR_W-1:0];
        sfdm_pkg::CFG_ROI_START:    cfg_d.roi_start    = cfg_data_i[sfdm_pkg::ROW_W-1:0];
        sfdm_pkg::CFG_ROI_END:      cfg_d.roi_end      = cfg_data_i[sfdm_pkg::ROW_W-1:0];
        sfdm_pkg::CFG_REPORT_LIMIT: cfg_d.report_limit = cfg_data_i[sfdm_pkg::CNT_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold    <= sfdm_pkg::THRESHOLD_RST;
      cfg_q.roi_start    <= sfdm_pkg::ROI_START_RST;
      cfg_q.roi_end      <= sfdm_pkg::ROI_END_RST;
      cfg_q.report_limit <= sfdm_pkg::REPORT_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  sfdm_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_i      (pix_i),
    .adv_i      (adv),
    .s1_valid_o (s1_valid),
    .s1_item_o  (s1_item),
    .rd_en_o    (rd_en),
    .rd_idx_o   (rd_idx)
  );

  sfdm_ref_mem u_ref_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_idx_i  (rd_idx),
    .wr_en_i   (wr_en),
    .wr_idx_i  (wr_idx),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

  sfdm_eval u_eval (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .s1_valid_i (s1_valid),
    .s1_item_i  (s1_item),
    .ref_i      (rd_data),
    .adv_o      (adv),
    .wr_en_o    (wr_en),
    .wr_idx_o   (wr_idx),
    .wr_data_o  (wr_data),
    .res_o      (res_o)
  );

endmodule
